FILE: rtl/core/itst_pkg.sv
package itst_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int CODE_W      = 6;
   localparam int LEVEL_W     = 6;
   localparam int NUM_LISTS   = 4;
   localparam int ADDR_W      = 5;

   localparam logic [2:0] REG_BLANK       = 3'd0;
   localparam logic [2:0] REG_QUOTE_BLANK = 3'd1;
   localparam logic [2:0] REG_UL          = 3'd2;
   localparam logic [2:0] REG_INDENT_UL   = 3'd3;
   localparam logic [2:0] REG_OL          = 3'd4;
   localparam logic [2:0] REG_INDENT_OL   = 3'd5;
   localparam logic [2:0] REG_EOF         = 3'd6;

   localparam logic [CODE_W-1:0] BLANK_RESET       = 6'd0;
   localparam logic [CODE_W-1:0] QUOTE_BLANK_RESET = 6'd1;
   localparam logic [CODE_W-1:0] UL_RESET          = 6'd2;
   localparam logic [CODE_W-1:0] INDENT_UL_RESET   = 6'd3;
   localparam logic [CODE_W-1:0] OL_RESET          = 6'd4;
   localparam logic [CODE_W-1:0] INDENT_OL_RESET   = 6'd5;
   localparam logic [CODE_W-1:0] EOF_RESET         = 6'd6;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic               op;
      logic [CODE_W-1:0]  tag_code;
      logic [LEVEL_W-1:0] level;
   } req_type;

   typedef struct packed {
      logic signed [7:0] pre_level;
      logic              last_was_blank;
      logic [5:0]        stack_depth;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic               run;
      logic               push;
      logic [CODE_W-1:0]  tag;
      logic [LEVEL_W-1:0] level;
   } cell_ctl_type;

   typedef logic [NUM_LISTS-1:0][CODE_W-1:0] list_codes_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_SEL
   } state_type;

endpackage

FILE: rtl/core/indent_tag_stack_tracker.sv
// Indent tag stack tracker. Each request (push of a tag at an indent level, or a query for the
// enclosing list level) passes through capture, an update/compare step in the row of stack
// cells, and a select step that picks the nearest qualifying list entry and the stack depth.
// A request is taken while the previous response still waits in the output register; the select
// step holds until that register is free. The stack keeps 32 entries with strictly increasing
// levels; a push into a full stack is dropped and reported as overflow. Configuration must be
// written through the csr_ port only while the block is idle; the block does not enforce this.
module indent_tag_stack_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  itst_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output itst_pkg::rsp_type             rsp_payload,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [itst_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic [itst_pkg::CODE_W-1:0] blank_ff, quote_blank_ff, ul_ff, indent_ul_ff;
   logic [itst_pkg::CODE_W-1:0] ol_ff, indent_ol_ff, eof_ff;
   logic [itst_pkg::CODE_W-1:0] recent_tag_ff, recent_tag_in;

   itst_pkg::state_type state_ff, state_in;
   itst_pkg::req_type   cmd_ff, cmd_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   itst_pkg::rsp_type   rsp_ff, rsp_in;

   itst_pkg::cell_ctl_type   ctl;
   itst_pkg::list_codes_type codes;
   logic                     csr_write;
   logic                     req_accept;
   logic                     nonblank;
   logic                     load_rsp;

   logic [itst_pkg::STACK_DEPTH:0]                          keep_chain;
   logic [itst_pkg::STACK_DEPTH:0][itst_pkg::NUM_LISTS-1:0] hit_chain;
   logic [itst_pkg::STACK_DEPTH:0]                          qual_chain;
   logic [itst_pkg::STACK_DEPTH:0]                          used_vec;
   logic [itst_pkg::STACK_DEPTH-1:0]                        qual_top;
   logic [itst_pkg::STACK_DEPTH-1:0][itst_pkg::LEVEL_W-1:0] cell_level;
   logic [itst_pkg::LEVEL_W-1:0]                            pick_level;
   logic [itst_pkg::DEPTH_W-1:0]                            depth;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ff       <= itst_pkg::BLANK_RESET;
         quote_blank_ff <= itst_pkg::QUOTE_BLANK_RESET;
         ul_ff          <= itst_pkg::UL_RESET;
         indent_ul_ff   <= itst_pkg::INDENT_UL_RESET;
         ol_ff          <= itst_pkg::OL_RESET;
         indent_ol_ff   <= itst_pkg::INDENT_OL_RESET;
         eof_ff         <= itst_pkg::EOF_RESET;
      end else if (csr_write) begin
         case (csr_paddr[itst_pkg::ADDR_W-1:2])
            itst_pkg::REG_BLANK:       blank_ff       <= csr_pwdata[itst_pkg::CODE_W-1:0];
            itst_pkg::REG_QUOTE_BLANK: quote_blank_ff <= csr_pwdata[itst_pkg::CODE_W-1:0];
            itst_pkg::REG_UL:          ul_ff          <= csr_pwdata[itst_pkg::CODE_W-1:0];
            itst_pkg::REG_INDENT_UL:   indent_ul_ff   <= csr_pwdata[itst_pkg::CODE_W-1:0];
            itst_pkg::REG_OL:          ol_ff          <= csr_pwdata[itst_pkg::CODE_W-1:0];
            itst_pkg::REG_INDENT_OL:   indent_ol_ff   <= csr_pwdata[itst_pkg::CODE_W-1:0];
            itst_pkg::REG_EOF:         eof_ff         <= csr_pwdata[itst_pkg::CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[itst_pkg::ADDR_W-1:2])
         itst_pkg::REG_BLANK:       csr_prdata = {26'd0, blank_ff};
         itst_pkg::REG_QUOTE_BLANK: csr_prdata = {26'd0, quote_blank_ff};
         itst_pkg::REG_UL:          csr_prdata = {26'd0, ul_ff};
         itst_pkg::REG_INDENT_UL:   csr_prdata = {26'd0, indent_ul_ff};
         itst_pkg::REG_OL:          csr_prdata = {26'd0, ol_ff};
         itst_pkg::REG_INDENT_OL:   csr_prdata = {26'd0, indent_ol_ff};
         itst_pkg::REG_EOF:         csr_prdata = {26'd0, eof_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // cell row
   assign codes    = {indent_ol_ff, ol_ff, indent_ul_ff, ul_ff};
   assign nonblank = (cmd_ff.tag_code != blank_ff) && (cmd_ff.tag_code != quote_blank_ff);

   always_comb begin
      ctl.run   = (state_ff == itst_pkg::ST_RUN);
      ctl.push  = (cmd_ff.op == itst_pkg::OP_PUSH) && nonblank;
      ctl.tag   = cmd_ff.tag_code;
      ctl.level = cmd_ff.level;
   end

   assign keep_chain[0]                    = 1'b1;
   assign hit_chain[itst_pkg::STACK_DEPTH]  = '0;
   assign qual_chain[itst_pkg::STACK_DEPTH] = 1'b0;
   assign used_vec[itst_pkg::STACK_DEPTH]   = 1'b0;

   for (genvar i = 0; i < itst_pkg::STACK_DEPTH; i++) begin : g_cell
      itst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .codes      (codes),
         .below_keep (keep_chain[i]),
         .hit_above  (hit_chain[i+1]),
         .hit_out    (hit_chain[i]),
         .qual_above (qual_chain[i+1]),
         .qual_out   (qual_chain[i]),
         .keep       (keep_chain[i+1]),
         .used       (used_vec[i]),
         .qual_top   (qual_top[i]),
         .level_out  (cell_level[i])
      );
   end

   always_comb begin
      pick_level = '0;
      depth      = '0;
      for (int i = 0; i < itst_pkg::STACK_DEPTH; i++) begin
         pick_level = pick_level | cell_level[i];
         if (used_vec[i] && !used_vec[i+1]) begin
            depth = depth | itst_pkg::DEPTH_W'(i + 1);
         end
      end
   end

   // sequencer
   assign req_stall  = (state_ff != itst_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_rsp   = (state_ff == itst_pkg::ST_SEL) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ovf_in        = ovf_ff;
      recent_tag_in = recent_tag_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      case (state_ff)
         itst_pkg::ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = req_payload;
               state_in = itst_pkg::ST_RUN;
            end
         end
         itst_pkg::ST_RUN: begin
            ovf_in = ctl.push && keep_chain[itst_pkg::STACK_DEPTH];
            if (cmd_ff.op == itst_pkg::OP_PUSH) begin
               recent_tag_in = cmd_ff.tag_code;
            end
            state_in = itst_pkg::ST_SEL;
         end
         itst_pkg::ST_SEL: begin
            if (load_rsp) begin
               rsp_valid_in          = 1'b1;
               rsp_in.pre_level      = ((cmd_ff.op == itst_pkg::OP_QUERY) && qual_chain[0])
                                       ? $signed({2'b00, pick_level} + 8'd1) : -8'sd1;
               rsp_in.last_was_blank = (recent_tag_ff == blank_ff);
               rsp_in.stack_depth    = 6'(depth);
               rsp_in.overflow       = ovf_ff;
               state_in              = itst_pkg::ST_IDLE;
            end
         end
         default: state_in = itst_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itst_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         recent_tag_ff <= itst_pkg::EOF_RESET;
         ovf_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         recent_tag_ff <= recent_tag_in;
         ovf_ff        <= ovf_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/core/itst_cell.sv
module itst_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  itst_pkg::cell_ctl_type              ctl,
   input  itst_pkg::list_codes_type            codes,
   input  logic                                below_keep,
   input  logic [itst_pkg::NUM_LISTS-1:0]      hit_above,
   output logic [itst_pkg::NUM_LISTS-1:0]      hit_out,
   input  logic                                qual_above,
   output logic                                qual_out,
   output logic                                keep,
   output logic                                used,
   output logic                                qual_top,
   output logic [itst_pkg::LEVEL_W-1:0]        level_out
);

   logic                            used_ff, used_in;
   logic [itst_pkg::CODE_W-1:0]     tag_ff, tag_in;
   logic [itst_pkg::LEVEL_W-1:0]    level_ff, level_in;
   logic                            qual_ff, qual_in;
   logic [itst_pkg::NUM_LISTS-1:0]  hit;
   logic                            nearest;

   always_comb begin
      keep = used_ff && (level_ff < ctl.level);
      for (int k = 0; k < itst_pkg::NUM_LISTS; k++) begin
         hit[k] = used_ff && (tag_ff == codes[k]);
      end
      hit_out = hit | hit_above;
      nearest = |(hit & ~hit_above);

      used_in  = used_ff;
      tag_in   = tag_ff;
      level_in = level_ff;
      qual_in  = qual_ff;
      if (ctl.run) begin
         qual_in = nearest && ({1'b0, ctl.level} >= ({1'b0, level_ff} + 7'd2));
         if (ctl.push && !keep) begin
            if (below_keep) begin
               used_in  = 1'b1;
               tag_in   = ctl.tag;
               level_in = ctl.level;
            end else begin
               used_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         qual_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         qual_ff <= qual_in;
      end
      tag_ff   <= tag_in;
      level_ff <= level_in;
   end

   assign used      = used_ff;
   assign qual_out  = qual_ff | qual_above;
   assign qual_top  = qual_ff && !qual_above;
   assign level_out = qual_top ? level_ff : '0;

endmodule

FILE: tb/indent_tag_stack_checker.sv
module indent_tag_stack_checker
   import itst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_type           req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_type           rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic              csr_pready,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output int                fail_count,
   output int                pending,
   output int                checked,
   output int                overflows
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [CODE_W-1:0]  blank_tag;
   logic [CODE_W-1:0]  qblank_tag;
   logic [CODE_W-1:0]  list_tags [NUM_LISTS];
   logic [CODE_W-1:0]  tag_mem [STACK_DEPTH];
   logic [LEVEL_W-1:0] level_mem [STACK_DEPTH];
   int                 depth;
   logic [CODE_W-1:0]  recent_tag;
   rsp_type            awaited_rsp_q [$];

   // One line of the document: push updates the indent stack, query looks for
   // the enclosing list level.
   function automatic rsp_type track_line(req_type r);
      rsp_type a;
      int      best;
      int      hit;
      int      i;
      int      k;
      a    = '0;
      best = -1;
      if (r.op == OP_PUSH) begin
         if (r.tag_code != blank_tag && r.tag_code != qblank_tag) begin
            while (depth > 0 && level_mem[depth-1] >= r.level) depth--;
            if (depth < STACK_DEPTH) begin
               tag_mem[depth]   = r.tag_code;
               level_mem[depth] = r.level;
               depth++;
            end else begin
               a.overflow = 1'b1;
            end
         end
         recent_tag = r.tag_code;
      end else begin
         for (k = 0; k < NUM_LISTS; k++) begin
            hit = -1;
            for (i = 0; i < depth; i++)
               if (tag_mem[i] == list_tags[k]) hit = i;
            if (hit >= 0 && int'(r.level) >= int'(level_mem[hit]) + 2 &&
                int'(level_mem[hit]) + 1 > best)
               best = int'(level_mem[hit]) + 1;
         end
      end
      a.pre_level      = best[7:0];
      a.last_was_blank = (recent_tag == blank_tag);
      a.stack_depth    = depth[5:0];
      return a;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         blank_tag    = BLANK_RESET;
         qblank_tag   = QUOTE_BLANK_RESET;
         list_tags[0] = UL_RESET;
         list_tags[1] = INDENT_UL_RESET;
         list_tags[2] = OL_RESET;
         list_tags[3] = INDENT_OL_RESET;
         depth        = 0;
         recent_tag   = EOF_RESET;
         awaited_rsp_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[ADDR_W-1:2])
               REG_BLANK:       blank_tag    = csr_pwdata[CODE_W-1:0];
               REG_QUOTE_BLANK: qblank_tag   = csr_pwdata[CODE_W-1:0];
               REG_UL:          list_tags[0] = csr_pwdata[CODE_W-1:0];
               REG_INDENT_UL:   list_tags[1] = csr_pwdata[CODE_W-1:0];
               REG_OL:          list_tags[2] = csr_pwdata[CODE_W-1:0];
               REG_INDENT_OL:   list_tags[3] = csr_pwdata[CODE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with no request outstanding: %p",
                           $realtime, rsp_payload);
            end else begin
               want = awaited_rsp_q.pop_front();
               checked++;
               if (want.overflow) overflows++;
               if (want.pre_level !== rsp_payload.pre_level ||
                   want.last_was_blank !== rsp_payload.last_was_blank ||
                   want.stack_depth !== rsp_payload.stack_depth ||
                   want.overflow !== rsp_payload.overflow) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: response %0d wrong (expected/actual)",
                              $realtime, checked);
                     $display("  pre %0d/%0d blank %0b/%0b depth %0d/%0d ovf %0b/%0b",
                              want.pre_level, rsp_payload.pre_level,
                              want.last_was_blank, rsp_payload.last_was_blank,
                              want.stack_depth, rsp_payload.stack_depth,
                              want.overflow, rsp_payload.overflow);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_rsp_q.push_back(track_line(req_payload));
      end
      pending = awaited_rsp_q.size();
   end

endmodule

FILE: tb/tb_indent_tag_stack_tracker.sv
module tb_indent_tag_stack_tracker;
   timeunit 1ns;
   timeprecision 1ps;
   import itst_pkg::*;

   localparam int         WATCHDOG_LIMIT = 3000;
   localparam int         PHASE_ITEMS    = 170;
   localparam int         NUM_SETTINGS   = 7;
   localparam logic [2:0] REG_SPARE      = 3'd7;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]       csr_pwdata  = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   logic              req_taken = 1'b0;
   logic              csr_taken = 1'b0;
   int                fail_count;
   int                pending;
   int                checked;
   int                overflows;
   int                idle_cycles = 0;
   int                burst_left  = 0;
   int                n_sent      = 0;
   int                n_queries   = 0;
   int                n_settings  = 1;
   int                stall_mode  = 0;
   int                stall_left  = 0;
   int                stall_run   = 0;
   logic [CODE_W-1:0] cfg_val [8];

   indent_tag_stack_tracker u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   indent_tag_stack_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .overflows   (overflows)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      csr_taken <= csr_psel && csr_penable && csr_pwrite && csr_pready;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side back-pressure: free-flowing, light, heavy, long runs
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_run == 0) begin
               stall_run = $urandom_range(1, 20);
               rsp_stall <= ~rsp_stall;
            end else begin
               stall_run--;
            end
         end
      endcase
   end

   function automatic logic [LEVEL_W-1:0] clamp_level(int v);
      if (v < 0) return '0;
      if (v > 63) return '1;
      return v[LEVEL_W-1:0];
   endfunction

   function automatic logic [CODE_W-1:0] list_tag();
      return cfg_val[REG_UL + $urandom_range(0, NUM_LISTS - 1)];
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_op(input logic op, input logic [CODE_W-1:0] tag,
                          input logic [LEVEL_W-1:0] lvl);
      req_type r;
      int      gap;
      r.op       = op;
      r.tag_code = tag;
      r.level    = lvl;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(negedge clock); while (!req_taken);
      n_sent++;
      if (op == OP_QUERY) n_queries++;
   endtask

   task automatic apply_settings();
      for (int i = int'(REG_BLANK); i <= int'(REG_SPARE); i++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {i[2:0], 2'b00};
         csr_pwdata  <= {26'($urandom_range(0, 32'h03ff_ffff)), cfg_val[i]};
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(negedge clock); while (!csr_taken);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic run_phase(int n);
      int start;
      int kind;
      int cur;
      int pick;
      int cnt;
      start = n_sent;
      while (n_sent - start < n) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            // nested list block with content
            cur = $urandom_range(0, 2);
            repeat ($urandom_range(4, 30)) begin
               pick = $urandom_range(0, 99);
               if (pick < 55) begin
                  send_op(OP_PUSH, list_tag(), clamp_level(cur));
                  if ($urandom_range(0, 3) == 0) cur = $urandom_range(0, cur);
                  else cur = int'(clamp_level(cur + 1));
               end else if (pick < 75) begin
                  send_op(OP_QUERY, CODE_W'($urandom_range(0, 63)),
                          clamp_level(cur + $urandom_range(0, 3) - 1));
               end else if (pick < 85) begin
                  send_op(OP_PUSH, $urandom_range(0, 1) ? cfg_val[REG_BLANK]
                                                        : cfg_val[REG_QUOTE_BLANK],
                          LEVEL_W'($urandom_range(0, 63)));
               end else begin
                  send_op(OP_PUSH, CODE_W'($urandom_range(0, 63)), clamp_level(cur));
               end
            end
         end else if (kind < 7) begin
            // climb until the stack is full, then push past it
            cur = $urandom_range(0, 4);
            cnt = STACK_DEPTH + $urandom_range(0, 4);
            for (int j = 0; j < cnt; j++)
               send_op(OP_PUSH, list_tag(), clamp_level(cur + j));
            send_op(OP_QUERY, CODE_W'($urandom_range(0, 63)), '1);
            send_op(OP_PUSH, list_tag(), '1);
         end else begin
            repeat ($urandom_range(1, 8))
               send_op(1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 63)),
                       LEVEL_W'($urandom_range(0, 63)));
         end
      end
   endtask

   initial begin
      cfg_val = '{BLANK_RESET, QUOTE_BLANK_RESET, UL_RESET, INDENT_UL_RESET,
                  OL_RESET, INDENT_OL_RESET, EOF_RESET, '0};
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_op(OP_QUERY, '1, '1);
      send_op(OP_PUSH, BLANK_RESET, 6'd5);
      send_op(OP_PUSH, QUOTE_BLANK_RESET, 6'd3);
      send_op(OP_PUSH, UL_RESET, 6'd0);
      send_op(OP_PUSH, OL_RESET, 6'd2);
      send_op(OP_PUSH, INDENT_UL_RESET, 6'd3);
      send_op(OP_PUSH, INDENT_OL_RESET, 6'd4);
      send_op(OP_PUSH, '1, '1);
      send_op(OP_QUERY, '0, 6'd0);
      send_op(OP_QUERY, '0, 6'd2);
      send_op(OP_QUERY, '0, 6'd5);
      send_op(OP_QUERY, '0, 6'd6);
      send_op(OP_QUERY, '0, '1);
      // nearest list entry too deep hides an outer one that would qualify
      send_op(OP_PUSH, UL_RESET, 6'd2);
      send_op(OP_QUERY, '0, 6'd3);
      send_op(OP_PUSH, 6'd7, 6'd1);
      send_op(OP_PUSH, EOF_RESET, 6'd0);
      send_op(OP_PUSH, BLANK_RESET, '1);
      send_op(OP_QUERY, '1, '1);
      send_op(OP_PUSH, '1, 6'd0);
      run_phase(PHASE_ITEMS);

      for (int s = 1; s < NUM_SETTINGS; s++) begin
         wait_drained();
         repeat (4) @(negedge clock);
         case (s)
            1: cfg_val = '{6'd63, 6'd62, 6'd0, 6'd0, 6'd1, 6'd1, 6'd63, 6'd0};
            2: cfg_val = '{6'd0, 6'd0, 6'd63, 6'd63, 6'd63, 6'd62, 6'd0, 6'd63};
            default:
               foreach (cfg_val[i])
                  cfg_val[i] = (s % 2) ? CODE_W'($urandom_range(0, 7))
                                       : CODE_W'($urandom_range(0, 63));
         endcase
         apply_settings();
         n_settings++;
         run_phase(PHASE_ITEMS);
      end

      wait_drained();
      repeat (10) @(negedge clock);
      $display("Sent %0d requests (%0d queries) under %0d register settings.",
               n_sent, n_queries, n_settings);
      $display("Compared %0d results, %0d of them pushes dropped on a full stack.",
               checked, overflows);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
